// ----- hw/rtl/b64d_pkg.sv -----
// Package for the base64 stream decoder: queue entry type, character decode
// function and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  // Number of decoded groups that can wait between the front and back parts.
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b64d_sextet_t;

  // One finished group. Mask bit 0, 1, 2 marks bytes 1, 2, 3 of the triplet.
  typedef struct packed {
    logic [23:0] triplet;
    logic [2:0]  mask;
    logic        end_flag;
  } b64d_job_t;

  function automatic b64d_sextet_t sextet_of(input logic [7:0] ch);
    b64d_sextet_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (ch >= "A" && ch <= "Z") begin
      s.val = 6'(ch - 8'("A"));
    end else if (ch >= "a" && ch <= "z") begin
      s.val = 6'(ch - 8'("a") + 8'd26);
    end else if (ch >= "0" && ch <= "9") begin
      s.val = 6'(ch - 8'("0") + 8'd52);
    end else if (ch == "+" || ch == "-") begin
      s.val = SextetPlus;
    end else if (ch == "/" || ch == "_") begin
      s.val = SextetSlash;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/b64d_if.sv -----
// Channel interfaces of the base64 stream decoder: character input and
// decoded byte output, each with a source and a sink modport.
`timescale 1ns / 1ps
`default_nettype none

interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_of_run;
  logic       end_mark;

  modport source (output valid, output data_byte, output byte_present,
                  output last_of_run, output end_mark, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input last_of_run, input end_mark, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/b64d_front.sv -----
// Front part: accepts characters, decodes them to sextets and gathers groups
// of four. Depends on b64d_pkg and b64d_if.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front import b64d_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b64d_char_if.sink  in_i,
  input  wire logic  full_i,
  output b64d_job_t  job_o,
  output logic       push_o
);

  logic [1:0]   pos_q, pos_d;
  logic [17:0]  store_q, store_d, store_n;
  logic [2:0]   pres_q, pres_d, pres_n;
  b64d_sextet_t sx;
  logic         fire;
  logic         done;
  logic         last_valid;
  logic [5:0]   last_sx;

  assign in_i.ready = !full_i;
  assign fire       = in_i.valid && !full_i;
  assign sx         = sextet_of(in_i.char_code);

  always_comb begin
    store_n    = store_q;
    pres_n     = pres_q;
    last_valid = 1'b0;
    last_sx    = 6'd0;
    case (pos_q)
      2'd0: begin
        if (sx.ok) begin
          store_n[17:12] = sx.val;
          pres_n[2]      = 1'b1;
        end
      end
      2'd1: begin
        if (sx.ok) begin
          store_n[11:6] = sx.val;
          pres_n[1]     = 1'b1;
        end
      end
      2'd2: begin
        if (sx.ok) begin
          store_n[5:0] = sx.val;
          pres_n[0]    = 1'b1;
        end
      end
      default: begin
        last_valid = sx.ok;
        last_sx    = sx.ok ? sx.val : 6'd0;
      end
    endcase
  end

  assign done = (pos_q == 2'd3) || in_i.end_of_text;

  always_comb begin
    job_o.triplet  = {store_n, last_sx};
    job_o.mask     = {last_valid, pres_n[0], pres_n[2] & pres_n[1]};
    job_o.end_flag = in_i.end_of_text;
  end

  // A group without any byte only produces a result when it closes the text.
  assign push_o = fire && done && ((job_o.mask != 3'b000) || in_i.end_of_text);

  always_comb begin
    pos_d   = pos_q;
    store_d = store_q;
    pres_d  = pres_q;
    if (fire) begin
      if (done) begin
        pos_d   = 2'd0;
        store_d = 18'd0;
        pres_d  = 3'd0;
      end else begin
        pos_d   = pos_q + 2'd1;
        store_d = store_n;
        pres_d  = pres_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 2'd0;
      store_q <= 18'd0;
      pres_q  <= 3'd0;
    end else begin
      pos_q   <= pos_d;
      store_q <= store_d;
      pres_q  <= pres_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/b64d_queue.sv -----
// Short queue of finished groups between the front and back parts.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire b64d_job_t job_i,
  input  wire logic      pop_i,
  output b64d_job_t      job_o,
  output logic           avail_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign avail_o = (count_q != CntW'(0));
  assign full_o  = (count_q == CntW'(Depth));
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/b64d_back.sv -----
// Back part: drains the group at the head of the queue one byte per cycle, while
// the output is not stalled, into the output register. Depends on b64d_pkg and b64d_if.
`timescale 1ns / 1ps
`default_nettype none

module b64d_back import b64d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire b64d_job_t job_i,
  input  wire logic      avail_i,
  output logic           pop_o,
  b64d_byte_if.source    out_o
);

  logic [2:0] sent_q, sent_d;
  logic [2:0] rem, take;
  logic       last;
  logic       emit;
  logic [7:0] byte_sel;

  logic       valid_q;
  logic [7:0] data_q;
  logic       present_q, last_q, end_q;

  assign rem = job_i.mask & ~sent_q;

  always_comb begin
    take     = 3'b000;
    byte_sel = 8'd0;
    if (rem[0]) begin
      take     = 3'b001;
      byte_sel = job_i.triplet[23:16];
    end else if (rem[1]) begin
      take     = 3'b010;
      byte_sel = job_i.triplet[15:8];
    end else if (rem[2]) begin
      take     = 3'b100;
      byte_sel = job_i.triplet[7:0];
    end
  end

  // A group with no bytes left to send is the empty end marker.
  assign last  = ((rem & ~take) == 3'b000);
  assign emit  = avail_i && (!valid_q || out_o.ready);
  assign pop_o = emit && last;

  always_comb begin
    sent_d = sent_q;
    if (emit) begin
      sent_d = last ? 3'b000 : (sent_q | take);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= 3'b000;
      valid_q <= 1'b0;
    end else begin
      sent_q <= sent_d;
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q    <= byte_sel;
      present_q <= (take != 3'b000);
      last_q    <= last;
      end_q     <= last && job_i.end_flag;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.data_byte    = data_q;
  assign out_o.byte_present = present_q;
  assign out_o.last_of_run  = last_q;
  assign out_o.end_mark     = end_q;

endmodule

`default_nettype wire

// ----- hw/rtl/base64url_stream_decoder.sv -----
// Base64 stream decoder (standard and URL-safe alphabets), one character per item.
// The first result of a group goes through the queue, then the output register.
// Throughput: one item per cycle in while the queue is not full; the back part sends
// one byte per cycle from the queue head while the output is not stalled.
// Reset (asynchronous, active low) clears group state, queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_decoder import b64d_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  b64d_char_if.sink   in_i,
  b64d_byte_if.source out_o
);

  b64d_job_t push_job, head_job;
  logic      push, pop, avail, full;

  b64d_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .job_o  (push_job),
    .push_o (push)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .avail_o (avail),
    .full_o  (full)
  );

  b64d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .avail_i (avail),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/b64d_checker.sv -----
// Port-level checks for the base64 stream decoder, bound to the top level.
// Depends on the top level's interface ports only.
`timescale 1ns / 1ps
`default_nettype none

module b64d_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] data_byte_i,
  input wire logic       byte_present_i,
  input wire logic       last_of_run_i,
  input wire logic       end_mark_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // The end of a string always closes the run of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && end_mark_i |-> last_of_run_i)
    else $error("end mark without last of run");

  // An empty result only ever marks the end of the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_present_i |-> end_mark_i && last_of_run_i)
    else $error("empty result that is not an end marker");

  // An empty result carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_present_i |-> data_byte_i == 8'd0)
    else $error("empty result with nonzero data");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .data_byte_i    (out_o.data_byte),
  .byte_present_i (out_o.byte_present),
  .last_of_run_i  (out_o.last_of_run),
  .end_mark_i     (out_o.end_mark)
);

`default_nettype wire
